### design/lbs_pkg.sv
// lbs_pkg: shared types, codes and fixed-point helpers for linear blend skinning.
// No dependencies.
package lbs_pkg;

	localparam int WORD_W     = 32;
	localparam int WEIGHT_W   = 16;
	localparam int ROW_COUNT  = 3;
	localparam int ROW_LEN    = 4;
	localparam int KEPT_COUNT = ROW_COUNT * ROW_LEN;
	localparam int WIDE_W     = 67;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_SKIN  = 1'b1;

	typedef logic signed [WORD_W-1:0] q16_t;
	typedef logic signed [WIDE_W-1:0] wide_t;
	typedef logic [KEPT_COUNT-1:0][WORD_W-1:0] mat_t;

	typedef struct packed {
		logic valid;
		logic bad;
	} meta_t;

	function automatic q16_t sat_q16(input wide_t v);
		wide_t hi;
		wide_t lo;
		hi = wide_t'(64'sh7FFF_FFFF);
		lo = -wide_t'(64'sh8000_0000);
		if (v > hi) begin
			return q16_t'(hi);
		end else if (v < lo) begin
			return q16_t'(lo);
		end
		return q16_t'(v);
	endfunction

endpackage

### design/lbs_row.sv
// lbs_row: one output row, blended row times (x, y, z, 1), rounded and saturated.
// Depends on lbs_pkg.
module lbs_row import lbs_pkg::*; (
	input  logic clk,
	input  logic en,
	input  q16_t b [ROW_LEN],
	input  q16_t pos [ROW_COUNT],
	output q16_t res
);

	logic signed [63:0] p_s6 [ROW_COUNT];
	q16_t               b3_s6;
	wide_t              t_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < ROW_COUNT; c++) begin
				p_s6[c] <= b[c] * pos[c];
			end
			b3_s6 <= b[ROW_LEN-1];
			t_s7  <= wide_t'(p_s6[0]) + wide_t'(p_s6[1]) + wide_t'(p_s6[2])
				+ (wide_t'(b3_s6) <<< 16);
			res   <= sat_q16((t_s7 + wide_t'(32768)) >>> 16);
		end
	end

endmodule

### design/linear_blend_vertex_skinning_top.sv
// Linear blend skinning, four influences, Q16.16 joint matrix table in one memory.
// Vertices pass the table read, weighted sum, blend and row stages. Each vertex raises
// in_stall for a second read (two ports read four joints as two pairs); writes do not.
// Reset clears pipeline control only; table contents are undefined until written.
// Depends on lbs_pkg and lbs_row.
module linear_blend_vertex_skinning_top import lbs_pkg::*; #(
	parameter int JOINT_COUNT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [31:0] joint_indices,
	input  logic [15:0] weight_0,
	input  logic [15:0] weight_1,
	input  logic [15:0] weight_2,
	input  logic [15:0] weight_3,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic [5:0]  table_joint,
	input  logic [3:0]  table_entry,
	input  logic signed [31:0] table_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic        bad_joint
);

	localparam int AW = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;

	mat_t mem [JOINT_COUNT];
	mat_t rd0_q, rd1_q;

	logic adv, acc, acc_skin, acc_wr;
	logic ph1_q;
	meta_t m_s2, m_s3, m_s4, m_s5, m_s6, m_s7;
	logic bad_in;
	logic [7:0] idx [4];
	logic [7:0] idx2_q, idx3_q;
	logic [AW-1:0] ra0, ra1;
	logic [WEIGHT_W-1:0] w_q [4];
	q16_t pos_s1 [ROW_COUNT], pos_s2 [ROW_COUNT], pos_s3 [ROW_COUNT];
	q16_t pos_s4 [ROW_COUNT], pos_s5 [ROW_COUNT];
	logic bad_s1;
	logic signed [48:0] ma_s2 [KEPT_COUNT], mb_s2 [KEPT_COUNT];
	logic signed [48:0] mc_s3 [KEPT_COUNT], md_s3 [KEPT_COUNT];
	logic signed [49:0] sab_s3 [KEPT_COUNT];
	logic signed [51:0] s_s4 [KEPT_COUNT];
	q16_t b_s5 [KEPT_COUNT];
	q16_t row_b [ROW_COUNT][ROW_LEN];
	q16_t row_res [ROW_COUNT];
	logic out_bad_q;

	assign adv      = !out_valid || !out_stall;
	assign in_stall = ph1_q || !adv;
	assign acc      = in_valid && !in_stall;
	assign acc_skin = acc && (kind == KIND_SKIN);
	assign acc_wr   = acc && (kind == KIND_WRITE);

	always_comb begin
		bad_in = 1'b0;
		for (int k = 0; k < 4; k++) begin
			idx[k] = joint_indices[8*k +: 8];
			if ({1'b0, idx[k]} >= 9'(JOINT_COUNT)) begin
				bad_in = 1'b1;
			end
		end
	end

	assign ra0 = ph1_q ? idx2_q[AW-1:0] : idx[0][AW-1:0];
	assign ra1 = ph1_q ? idx3_q[AW-1:0] : idx[1][AW-1:0];

	always_ff @(posedge clk) begin
		if (acc_wr && ({3'b000, table_joint} < 9'(JOINT_COUNT))
				&& (table_entry < 4'(KEPT_COUNT))) begin
			mem[AW'(table_joint)][table_entry] <= table_value;
		end
		if (adv) begin
			rd0_q <= mem[ra0];
			rd1_q <= mem[ra1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph1_q     <= 1'b0;
			m_s2      <= '0;
			m_s3      <= '0;
			m_s4      <= '0;
			m_s5      <= '0;
			m_s6      <= '0;
			m_s7      <= '0;
			out_valid <= 1'b0;
		end else if (adv) begin
			ph1_q     <= acc_skin;
			m_s2      <= '{valid: ph1_q, bad: bad_s1};
			m_s3      <= m_s2;
			m_s4      <= m_s3;
			m_s5      <= m_s4;
			m_s6      <= m_s5;
			m_s7      <= m_s6;
			out_valid <= m_s7.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_skin) begin
			idx2_q <= idx[2];
			idx3_q <= idx[3];
			w_q    <= '{weight_0, weight_1, weight_2, weight_3};
			pos_s1 <= '{pos_x, pos_y, pos_z};
			bad_s1 <= bad_in;
		end
		if (adv) begin
			pos_s2 <= pos_s1;
			pos_s3 <= pos_s2;
			pos_s4 <= pos_s3;
			pos_s5 <= pos_s4;
			for (int e = 0; e < KEPT_COUNT; e++) begin
				ma_s2[e]  <= $signed({1'b0, w_q[0]}) * $signed(rd0_q[e]);
				mb_s2[e]  <= $signed({1'b0, w_q[1]}) * $signed(rd1_q[e]);
				mc_s3[e]  <= $signed({1'b0, w_q[2]}) * $signed(rd0_q[e]);
				md_s3[e]  <= $signed({1'b0, w_q[3]}) * $signed(rd1_q[e]);
				sab_s3[e] <= 50'(ma_s2[e]) + 50'(mb_s2[e]);
				s_s4[e]   <= 52'(sab_s3[e]) + 52'(mc_s3[e]) + 52'(md_s3[e]);
				b_s5[e]   <= sat_q16((wide_t'(s_s4[e]) + wide_t'(16384)) >>> 15);
			end
			out_bad_q <= m_s7.bad;
		end
	end

	always_comb begin
		for (int r = 0; r < ROW_COUNT; r++) begin
			for (int c = 0; c < ROW_LEN; c++) begin
				row_b[r][c] = b_s5[r*ROW_LEN + c];
			end
		end
	end

	for (genvar r = 0; r < ROW_COUNT; r++) begin : g_row
		lbs_row u_row (
			.clk (clk),
			.en  (adv),
			.b   (row_b[r]),
			.pos (pos_s5),
			.res (row_res[r])
		);
	end

	assign bad_joint = out_bad_q;
	assign out_x     = out_bad_q ? '0 : row_res[0];
	assign out_y     = out_bad_q ? '0 : row_res[1];
	assign out_z     = out_bad_q ? '0 : row_res[2];

	a_second_read: assert property (@(posedge clk) disable iff (!arst_n)
		acc_skin |=> in_stall)
		else $error("second read cycle not held");

	a_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(ph1_q && adv) |=> m_s2.valid)
		else $error("vertex lost between read phases");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bad_joint) |-> (out_x == 0 && out_y == 0 && out_z == 0))
		else $error("bad joint result not zero");

endmodule

### bench/tb_linear_blend_vertex_skinning_top.sv
// Testbench for linear_blend_vertex_skinning_top: a directed table and vertices, then
// random joint loads and vertex words, checked against fixed expected values or an
// in-bench skinning predictor. Depends on lbs_pkg and the skinning RTL.
module tb_linear_blend_vertex_skinning_top;
	import lbs_pkg::*;

	localparam int JOINTS    = 64;
	localparam int IDLE_MAX  = 5000;
	localparam int N_RANDOM  = 600;

	typedef struct {
		logic        kind;
		logic [31:0] ji;
		logic [15:0] w [4];
		q16_t        p [3];
		logic [5:0]  tj;
		logic [3:0]  te;
		q16_t        tv;
		bit          drain;
		bit          has_exp;
		q16_t        ex [3];
		logic        eb;
	} word_t;

	typedef struct {
		q16_t xyz [3];
		logic bad;
	} skin_res_t;

	logic clk, arst_n;
	logic in_valid, in_stall, kind;
	logic [31:0] joint_indices;
	logic [15:0] weight_0, weight_1, weight_2, weight_3;
	logic signed [31:0] pos_x, pos_y, pos_z, table_value;
	logic [5:0] table_joint;
	logic [3:0] table_entry;
	logic out_valid, out_stall, bad_joint;
	logic signed [31:0] out_x, out_y, out_z;

	word_t     stim_q [$];
	skin_res_t pending_q [$];
	int        joint_mem [JOINTS*16];
	int        loaded [$];
	int        errors = 0;
	int        idle_cycles = 0;

	linear_blend_vertex_skinning_top u_top (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic int sat_wide(logic signed [127:0] v);
		if (v > 128'sd2147483647)
			return 32'h7FFF_FFFF;
		if (v < -128'sd2147483648)
			return 32'h8000_0000;
		return int'(v);
	endfunction

	function automatic skin_res_t skin_predict(word_t it);
		skin_res_t r;
		longint s;
		logic signed [127:0] b [16];
		logic signed [127:0] acc, pp;
		int idx [4];
		r.bad = 0;
		for (int k = 0; k < 4; k++) begin
			idx[k] = int'(it.ji[8*k +: 8]);
			if (idx[k] >= JOINTS)
				r.bad = 1;
		end
		if (r.bad) begin
			for (int c = 0; c < 3; c++)
				r.xyz[c] = '0;
			return r;
		end
		for (int e = 0; e < 16; e++) begin
			s = 0;
			for (int k = 0; k < 4; k++)
				s += longint'({48'd0, it.w[k]}) * longint'(joint_mem[idx[k]*16 + e]);
			acc = s;
			b[e] = sat_wide((acc + 16384) >>> 15);
		end
		for (int row = 0; row < 3; row++) begin
			acc = b[row*4 + 3] <<< 16;
			for (int c = 0; c < 3; c++) begin
				pp = it.p[c];
				acc += b[row*4 + c] * pp;
			end
			r.xyz[row] = sat_wide((acc + 32768) >>> 16);
		end
		return r;
	endfunction

	function automatic word_t blank_word();
		word_t it;
		it.kind = KIND_SKIN;
		it.ji = '0;
		for (int k = 0; k < 4; k++)
			it.w[k] = '0;
		for (int c = 0; c < 3; c++) begin
			it.p[c] = '0;
			it.ex[c] = '0;
		end
		it.tj = '0;
		it.te = '0;
		it.tv = '0;
		it.drain = 0;
		it.has_exp = 0;
		it.eb = 0;
		return it;
	endfunction

	function automatic word_t load_word(int j, int e, int v);
		word_t it;
		it = blank_word();
		it.kind = KIND_WRITE;
		it.tj = 6'(j);
		it.te = 4'(e);
		it.tv = v;
		return it;
	endfunction

	function automatic word_t vert_word(logic [31:0] ji, int w0, int w1, int w2, int w3,
			int x, int y, int z, bit he, int ex, int ey, int ez, logic eb);
		word_t it;
		it = blank_word();
		it.ji = ji;
		it.w[0] = 16'(w0); it.w[1] = 16'(w1); it.w[2] = 16'(w2); it.w[3] = 16'(w3);
		it.p[0] = x; it.p[1] = y; it.p[2] = z;
		it.has_exp = he;
		it.ex[0] = ex; it.ex[1] = ey; it.ex[2] = ez;
		it.eb = eb;
		return it;
	endfunction

	function automatic int rand_coord();
		if ($urandom_range(0, 3) == 0)
			return int'($urandom);
		return int'($urandom_range(0, 8388607)) - 4194304;
	endfunction

	function automatic int rand_entry();
		if ($urandom_range(0, 3) == 0)
			return int'($urandom);
		return int'($urandom_range(0, 262143)) - 131072;
	endfunction

	function automatic int rand_weight();
		if ($urandom_range(0, 3) == 0)
			return int'($urandom_range(0, 65535));
		if ($urandom_range(0, 5) == 0)
			return 0;
		return int'($urandom_range(0, 32768));
	endfunction

	task automatic build_stimulus();
		int n, j, e, t, nv, bk;
		int ord [16];
		logic [31:0] ji;
		word_t dw;
		// identity matrix in joint 0
		for (e = 0; e < 16; e++)
			stim_q.push_back(load_word(0, e, (e % 5 == 0) ? 65536 : 0));
		loaded.push_back(0);
		stim_q.push_back(vert_word(32'h0, 32768, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1,
			1, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0));
		stim_q.push_back(vert_word(32'h0, 16384, 16384, 0, 0, -1, 0, 65536,
			1, -1, 0, 65536, 0));
		stim_q.push_back(vert_word(32'hFFFF_FFFF, 32768, 0, 0, 0, 5, 6, 7, 1, 0, 0, 0, 1));
		stim_q.push_back(vert_word(32'h4000_0000, 8192, 8192, 8192, 8192, 5, 6, 7,
			1, 0, 0, 0, 1));
		stim_q.push_back(vert_word(32'h0, 0, 0, 0, 0, 32'h7FFF_FFFF, 3, 4, 1, 0, 0, 0, 0));
		stim_q.push_back(vert_word(32'h0, 65535, 65535, 0, 0, 32'h7FFF_FFFF,
			32'h8000_0000, 12345, 0, 0, 0, 0, 0));

		n = 0;
		while (n < N_RANDOM) begin
			j = $urandom_range(0, JOINTS - 1);
			for (e = 0; e < 16; e++)
				ord[e] = e;
			for (e = 15; e > 0; e--) begin
				t = $urandom_range(0, e);
				{ord[e], ord[t]} = {ord[t], ord[e]};
			end
			for (e = 0; e < 16; e++)
				stim_q.push_back(load_word(j, ord[e], rand_entry()));
			n += 16;
			if (!(j inside {loaded}))
				loaded.push_back(j);
			nv = $urandom_range(1, 10);
			for (int v = 0; v < nv; v++) begin
				if ($urandom_range(0, 9) == 0) begin
					ji = $urandom;
					bk = $urandom_range(0, 3);
					ji[8*bk + 6 +: 2] = ji[8*bk + 6 +: 2] | 2'($urandom_range(1, 3));
				end else begin
					for (int k = 0; k < 4; k++)
						ji[8*k +: 8] = 8'(loaded[$urandom_range(0, loaded.size() - 1)]);
				end
				stim_q.push_back(vert_word(ji, rand_weight(), rand_weight(), rand_weight(),
					rand_weight(), rand_coord(), rand_coord(), rand_coord(), 0, 0, 0, 0, 0));
				n++;
			end
			if (n > N_RANDOM / 2 && n < N_RANDOM / 2 + 30) begin
				dw = blank_word();
				dw.drain = 1;
				stim_q.push_back(dw);
			end
		end
	endtask

	// receiver stall pattern
	initial begin
		int mode, left;
		out_stall <= 0;
		mode = 0;
		left = 0;
		forever begin
			@(posedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(5, 60);
			end
			left--;
			case (mode)
				0: out_stall <= 0;
				1: out_stall <= ($urandom_range(0, 1) == 1);
				2: out_stall <= ($urandom_range(0, 7) != 0);
				default: out_stall <= ((left / 4) % 2 == 1);
			endcase
		end
	end

	always @(negedge clk) begin
		skin_res_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result x=%0d y=%0d z=%0d bad=%0b",
					$time, out_x, out_y, out_z, bad_joint);
				errors++;
			end else begin
				exp_r = pending_q.pop_front();
				if (out_x !== exp_r.xyz[0]) begin
					$display("%0t: out_x expected %0d actual %0d", $time, exp_r.xyz[0], out_x);
					errors++;
				end
				if (out_y !== exp_r.xyz[1]) begin
					$display("%0t: out_y expected %0d actual %0d", $time, exp_r.xyz[1], out_y);
					errors++;
				end
				if (out_z !== exp_r.xyz[2]) begin
					$display("%0t: out_z expected %0d actual %0d", $time, exp_r.xyz[2], out_z);
					errors++;
				end
				if (bad_joint !== exp_r.bad) begin
					$display("%0t: bad_joint expected %0b actual %0b", $time, exp_r.bad,
						bad_joint);
					errors++;
				end
			end
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles > IDLE_MAX) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int burst_left, gap;
		bit acc;
		skin_res_t r;
		word_t it;
		arst_n = 0;
		in_valid <= 0;
		kind <= 0;
		joint_indices <= '0;
		weight_0 <= '0; weight_1 <= '0; weight_2 <= '0; weight_3 <= '0;
		pos_x <= '0; pos_y <= '0; pos_z <= '0;
		table_joint <= '0; table_entry <= '0; table_value <= '0;
		build_stimulus();
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		burst_left = 0;
		foreach (stim_q[i]) begin
			it = stim_q[i];
			if (it.drain) begin
				in_valid <= 0;
				burst_left = 0;
				while (pending_q.size() > 0)
					@(posedge clk);
				continue;
			end
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 30);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap > 0) begin
					in_valid <= 0;
					repeat (gap) @(posedge clk);
				end
			end
			in_valid <= 1;
			kind <= it.kind;
			joint_indices <= it.ji;
			weight_0 <= it.w[0]; weight_1 <= it.w[1];
			weight_2 <= it.w[2]; weight_3 <= it.w[3];
			pos_x <= it.p[0]; pos_y <= it.p[1]; pos_z <= it.p[2];
			table_joint <= it.tj;
			table_entry <= it.te;
			table_value <= it.tv;
			do begin
				@(negedge clk);
				acc = !in_stall;
				if (acc) begin
					if (it.kind == KIND_WRITE) begin
						if (it.tj < JOINTS)
							joint_mem[it.tj*16 + it.te] = it.tv;
					end else if (it.has_exp) begin
						r.xyz = it.ex;
						r.bad = it.eb;
						pending_q.push_back(r);
					end else begin
						pending_q.push_back(skin_predict(it));
					end
				end
				@(posedge clk);
			end while (!acc);
			burst_left--;
		end
		in_valid <= 0;
		while (pending_q.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
